[hw/rtl/smpq_pkg.sv]
// Shared types and constants for the sorted minimum priority queue.
// Holds the request and response words, the status codes and the cell command.
// Depends on nothing.
`default_nettype none

package smpq_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 5;
    localparam int CAPACITY_DEFAULT = 16;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef enum logic
    {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_type_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        req_type_t req_type;
        value_t    value;
    } req_word_t;

    typedef struct packed
    {
        status_t                status;
        value_t                 removed_value;
        value_t                 front_value;
        logic [COUNT_WIDTH-1:0] entry_count;
        logic                   queue_empty;
    } rsp_word_t;

    typedef struct packed
    {
        logic   ins;
        logic   rem;
        value_t value;
    } cell_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/smpq_cell.sv]
// One slot of the sorted row: holds a value and compares it with the request.
// On insert it keeps, takes the new value or takes its left neighbor's value.
// On remove it takes its right neighbor's value. Depends on smpq_pkg.
`default_nettype none

module smpq_cell
(
    input  wire logic                clk,
    input  wire smpq_pkg::cell_cmd_t cmd,
    input  wire logic                occupied,
    input  wire smpq_pkg::value_t    prev_entry,
    input  wire logic                prev_lt,
    input  wire smpq_pkg::value_t    next_entry,
    output smpq_pkg::value_t         entry,
    output logic                     lt
);

    smpq_pkg::value_t entry_reg;
    smpq_pkg::value_t entry_next;

    assign lt    = occupied && (entry_reg < cmd.value);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (lt)
            begin
                entry_next = entry_reg;
            end
            else if (prev_lt)
            begin
                entry_next = cmd.value;
            end
            else
            begin
                entry_next = prev_entry;
            end
        end
        else if (cmd.rem)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

[hw/rtl/sorted_min_priority_queue_top.sv]
// Top level of the sorted minimum priority queue: a row of smpq_cell slots,
// the fill count and the registered response word. Depends on smpq_pkg and smpq_cell.
//
//   channel  dir  handshake           word
//   req      in   req_valid/req_stall req (req_word_t)
//   rsp      out  rsp_valid/rsp_stall rsp (rsp_word_t)
//
// All cells update in parallel at the accepting edge unless the queue is full on insert
// or empty on remove; the response is registered there, visible in the next cycle.
// A new request is accepted in every cycle unless a pending response is stalled.
// Reset clears the fill count and the response valid; the stored values are not cleared.
`default_nettype none

module sorted_min_priority_queue_top
#(
    parameter int CAPACITY = smpq_pkg::CAPACITY_DEFAULT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire smpq_pkg::req_word_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output smpq_pkg::rsp_word_t      rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                rsp_valid_reg;
    smpq_pkg::rsp_word_t rsp_reg;
    smpq_pkg::rsp_word_t rsp_next;

    logic                acc;
    logic                is_ins;
    logic                full;
    logic                empty;
    logic                ins_ok;
    logic                rem_ok;
    smpq_pkg::cell_cmd_t cmd;

    smpq_pkg::value_t    entries [CAPACITY];
    logic                lt      [CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign acc       = req_valid && !req_stall;
    assign is_ins    = (req.req_type == smpq_pkg::REQ_INSERT);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign ins_ok    = acc && is_ins && !full;
    assign rem_ok    = acc && !is_ins && !empty;

    assign cmd.ins   = ins_ok;
    assign cmd.rem   = rem_ok;
    assign cmd.value = req.value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        smpq_pkg::value_t prev_entry;
        logic             prev_lt;
        smpq_pkg::value_t next_entry;

        if (i == 0)
        begin : g_first
            assign prev_entry = req.value;
            assign prev_lt    = 1'b1;
        end
        else
        begin : g_mid
            assign prev_entry = entries[i-1];
            assign prev_lt    = lt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_entry = entries[i];
        end
        else
        begin : g_inner
            assign next_entry = entries[i+1];
        end

        smpq_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .occupied   (count_reg > CW'(i)),
            .prev_entry (prev_entry),
            .prev_lt    (prev_lt),
            .next_entry (next_entry),
            .entry      (entries[i]),
            .lt         (lt[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        rsp_next.status        = smpq_pkg::ST_OK;
        rsp_next.removed_value = '0;
        rsp_next.front_value   = empty ? '1 : entries[0];
        if (is_ins)
        begin
            if (full)
            begin
                rsp_next.status = smpq_pkg::ST_FULL;
            end
            else if (empty || !lt[0])
            begin
                rsp_next.front_value = req.value;
            end
        end
        else
        begin
            if (empty)
            begin
                rsp_next.status = smpq_pkg::ST_EMPTY;
            end
            else
            begin
                rsp_next.removed_value = entries[0];
                rsp_next.front_value   = (count_reg > CW'(1)) ? entries[1] : '1;
            end
        end
        rsp_next.entry_count = smpq_pkg::COUNT_WIDTH'(count_next);
        rsp_next.queue_empty = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (acc)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the fill count");

    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg > CW'(1) |-> !(entries[1] < entries[0]))
        else $error("first two slots out of order");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == smpq_pkg::ST_EMPTY |-> rsp_reg.queue_empty)
        else $error("empty status on a response with stored words");

endmodule

`default_nettype wire
